[rtl/qlns_pkg.sv]
// ----------------------------------------------------------------------------
// qlns_pkg
// Shared sizes, codes and controller/datapath interface types for the
// Q-learning next-hop selector.
// ----------------------------------------------------------------------------
package qlns_pkg;

	localparam int NB_SLOTS   = 16;
	localparam int PAIR_SLOTS = 64;

	localparam int NB_IW   = (NB_SLOTS > 1) ? $clog2(NB_SLOTS) : 1;
	localparam int NB_CW   = $clog2(NB_SLOTS + 1);
	localparam int PAIR_IW = (PAIR_SLOTS > 1) ? $clog2(PAIR_SLOTS) : 1;
	localparam int PAIR_CW = $clog2(PAIR_SLOTS + 1);

	localparam int IN_DATA_W  = 144;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_USER_W = 4;

	// 0.5 in s15.16
	localparam logic signed [31:0] Q_SEED = 32'sd32768;

	typedef enum logic [2:0] {
		VERDICT_OWN     = 3'd0,
		VERDICT_DELIVER = 3'd1,
		VERDICT_FORWARD = 3'd2,
		VERDICT_DROP    = 3'd3,
		VERDICT_UPDATED = 3'd4
	} verdict_t;

	typedef enum logic [1:0] {
		CFG_SELF_ADDR  = 2'd0,
		CFG_LEARN_RATE = 2'd1,
		CFG_DISCOUNT   = 2'd2,
		CFG_EXPIRY     = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [15:0] state;
		logic [15:0] action;
		logic [31:0] q;
	} pair_ent_t;

	typedef struct packed {
		logic load_in;
		logic scan_start;
		logic scan_run;
		logic nb_update;
		logic seed;
		logic sel_start;
		logic sel_run;
		logic sel_finish;
		logic mul1;
		logic diff;
		logic mul2;
		logic sat;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_done;
		logic sel_done;
		logic is_own;
		logic is_deliver;
		logic out_free;
	} stat_t;

endpackage

[rtl/qlns_datapath.sv]
// ----------------------------------------------------------------------------
// qlns_datapath
// Config registers, neighbor table, pair memory with its sweep, hop
// selection, Q update arithmetic and the output register.
// ----------------------------------------------------------------------------
module qlns_datapath (
	input  logic                             clk,
	input  logic                             arst_n,
	input  qlns_pkg::cmd_t                   cmd,
	output qlns_pkg::stat_t                  stat,
	input  logic                             cfg_valid,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_data,
	input  logic                             in_op,
	input  logic [qlns_pkg::IN_DATA_W-1:0]   in_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [qlns_pkg::OUT_DATA_W-1:0]  out_data,
	output logic [qlns_pkg::OUT_USER_W-1:0]  out_user
);

	// configuration
	logic [15:0] self_q;
	logic [16:0] lr_q;
	logic [16:0] disc_q;
	logic [31:0] exp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			self_q <= 16'd1;
			lr_q   <= 17'd6554;
			disc_q <= 17'd58982;
			exp_q  <= 32'd30000;
		end else if (cfg_valid) begin
			case (cfg_index)
				qlns_pkg::CFG_SELF_ADDR:  self_q <= cfg_data[15:0];
				qlns_pkg::CFG_LEARN_RATE: lr_q   <= cfg_data[16:0];
				qlns_pkg::CFG_DISCOUNT:   disc_q <= cfg_data[16:0];
				qlns_pkg::CFG_EXPIRY:     exp_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// latched item
	logic        op_q;
	logic [31:0] now_q;
	logic [15:0] sender_q, src_q, dst_q, us_q, ua_q;
	logic [31:0] reward_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			op_q     <= in_op;
			now_q    <= in_data[31:0];
			sender_q <= in_data[47:32];
			src_q    <= in_data[63:48];
			dst_q    <= in_data[79:64];
			us_q     <= in_data[95:80];
			ua_q     <= in_data[111:96];
			reward_q <= in_data[143:112];
		end
	end

	assign stat.is_own     = (src_q == self_q);
	assign stat.is_deliver = (dst_q == self_q);

	// neighbor table
	logic [qlns_pkg::NB_SLOTS-1:0] nb_valid_q;
	logic [15:0]                   nb_addr_q  [qlns_pkg::NB_SLOTS];
	logic [31:0]                   nb_last_q  [qlns_pkg::NB_SLOTS];
	logic signed [31:0]            nb_score_q [qlns_pkg::NB_SLOTS];

	logic                      nb_hit, nb_free_ok;
	logic [qlns_pkg::NB_IW-1:0] nb_hit_idx, nb_free_idx;

	always_comb begin
		nb_hit      = 1'b0;
		nb_hit_idx  = '0;
		nb_free_ok  = 1'b0;
		nb_free_idx = '0;
		for (int j = 0; j < qlns_pkg::NB_SLOTS; j++) begin
			if (nb_valid_q[j] && nb_addr_q[j] == sender_q) begin
				nb_hit     = 1'b1;
				nb_hit_idx = qlns_pkg::NB_IW'(j);
			end
			if (!nb_valid_q[j] && !nb_free_ok) begin
				nb_free_ok  = 1'b1;
				nb_free_idx = qlns_pkg::NB_IW'(j);
			end
		end
	end

	logic                       snd_ok_q;
	logic [qlns_pkg::NB_IW-1:0] snd_slot_q;

	always_ff @(posedge clk) begin
		if (cmd.nb_update) begin
			snd_ok_q   <= nb_hit || nb_free_ok;
			snd_slot_q <= nb_hit ? nb_hit_idx : nb_free_idx;
		end
	end

	// hop selection sweep
	logic [qlns_pkg::NB_CW-1:0] sel_cnt_q;
	logic [qlns_pkg::NB_IW-1:0] sel_j;
	logic                       sel_act, sel_expired, sel_better;
	logic [31:0]                sel_age;
	logic                       best_found_q;
	logic signed [31:0]         best_q;
	logic [15:0]                besta_q;

	assign sel_j       = sel_cnt_q[qlns_pkg::NB_IW-1:0];
	assign sel_act     = cmd.sel_run && (sel_cnt_q != qlns_pkg::NB_CW'(qlns_pkg::NB_SLOTS));
	assign sel_age     = now_q - nb_last_q[sel_j];
	assign sel_expired = sel_age > exp_q;
	assign sel_better  = !best_found_q || (nb_score_q[sel_j] > best_q) ||
	                     (nb_score_q[sel_j] == best_q && nb_addr_q[sel_j] < besta_q);
	assign stat.sel_done = (sel_cnt_q == qlns_pkg::NB_CW'(qlns_pkg::NB_SLOTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sel_cnt_q    <= '0;
			best_found_q <= 1'b0;
		end else if (cmd.sel_start) begin
			sel_cnt_q    <= '0;
			best_found_q <= 1'b0;
		end else if (sel_act) begin
			sel_cnt_q <= sel_cnt_q + 1'b1;
			if (nb_valid_q[sel_j] && !sel_expired && sel_better) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (sel_act && nb_valid_q[sel_j] && !sel_expired && sel_better) begin
			best_q  <= nb_score_q[sel_j];
			besta_q <= nb_addr_q[sel_j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_valid_q <= '0;
		end else begin
			if (cmd.nb_update && !nb_hit && nb_free_ok) begin
				nb_valid_q[nb_free_idx] <= 1'b1;
			end
			// drop stale neighbors as the sweep passes them
			if (sel_act && nb_valid_q[sel_j] && sel_expired) begin
				nb_valid_q[sel_j] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.nb_update) begin
			if (nb_hit) begin
				nb_last_q[nb_hit_idx] <= now_q;
			end else if (nb_free_ok) begin
				nb_addr_q[nb_free_idx] <= sender_q;
				nb_last_q[nb_free_idx] <= now_q;
			end
		end
	end

	// pair memory and its sweep
	logic [qlns_pkg::PAIR_SLOTS-1:0] pair_valid_q;
	qlns_pkg::pair_ent_t             pair_mem_q [qlns_pkg::PAIR_SLOTS];

	logic [qlns_pkg::PAIR_CW-1:0] rd_cnt_q;
	logic                         rd_issue;
	logic                         vld_s1;
	logic [qlns_pkg::PAIR_IW-1:0] idx_s1;
	qlns_pkg::pair_ent_t          ent_s1;

	logic                         mem_we;
	logic [qlns_pkg::PAIR_IW-1:0] mem_waddr;
	qlns_pkg::pair_ent_t          mem_wdata;

	assign rd_issue = cmd.scan_run && (rd_cnt_q != qlns_pkg::PAIR_CW'(qlns_pkg::PAIR_SLOTS));
	assign stat.scan_done = (rd_cnt_q == qlns_pkg::PAIR_CW'(qlns_pkg::PAIR_SLOTS)) && !vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else if (cmd.scan_start) begin
			rd_cnt_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= rd_issue;
			if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			pair_mem_q[mem_waddr] <= mem_wdata;
		end
		ent_s1 <= pair_mem_q[rd_cnt_q[qlns_pkg::PAIR_IW-1:0]];
		idx_s1 <= rd_cnt_q[qlns_pkg::PAIR_IW-1:0];
	end

	// match the swept entry against the key and against every neighbor
	logic [15:0]                   key_state, key_action, nb_state;
	logic                          hit_s1, key_hit;
	logic [qlns_pkg::NB_SLOTS-1:0] nb_match;

	assign key_state  = op_q ? us_q : self_q;
	assign key_action = op_q ? ua_q : sender_q;
	assign nb_state   = op_q ? ua_q : self_q;
	assign hit_s1     = vld_s1 && pair_valid_q[idx_s1];
	assign key_hit    = hit_s1 && ent_s1.state == key_state && ent_s1.action == key_action;

	always_comb begin
		for (int j = 0; j < qlns_pkg::NB_SLOTS; j++) begin
			nb_match[j] = hit_s1 && ent_s1.state == nb_state && nb_valid_q[j] &&
			              nb_addr_q[j] == ent_s1.action;
		end
	end

	logic                         found_q, free_found_q;
	logic [qlns_pkg::PAIR_IW-1:0] found_idx_q, free_idx_q;
	logic signed [31:0]           old_q;
	logic signed [31:0]           maxq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			maxq_q       <= '0;
		end else if (cmd.scan_start) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			maxq_q       <= '0;
		end else begin
			if (key_hit) begin
				found_q <= 1'b1;
			end
			if (vld_s1 && !pair_valid_q[idx_s1] && !free_found_q) begin
				free_found_q <= 1'b1;
			end
			if ((|nb_match) && $signed(ent_s1.q) > maxq_q) begin
				maxq_q <= ent_s1.q;
			end
		end
	end

	// an absent key reads as zero
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			old_q <= '0;
		end else if (key_hit) begin
			found_idx_q <= idx_s1;
			old_q       <= ent_s1.q;
		end
		if (vld_s1 && !pair_valid_q[idx_s1] && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
	end

	// absent pairs score zero
	always_ff @(posedge clk) begin
		for (int j = 0; j < qlns_pkg::NB_SLOTS; j++) begin
			if (cmd.scan_start) begin
				nb_score_q[j] <= '0;
			end else if (nb_match[j]) begin
				nb_score_q[j] <= ent_s1.q;
			end else if (cmd.seed && !found_q && free_found_q && snd_ok_q &&
			             snd_slot_q == qlns_pkg::NB_IW'(j)) begin
				nb_score_q[j] <= qlns_pkg::Q_SEED;
			end
		end
	end

	// Q update arithmetic
	logic [47:0]        prod1_q;
	logic signed [34:0] diff_q;
	logic signed [52:0] prod2_q;
	logic signed [17:0] lr_s;
	logic signed [36:0] step;
	logic signed [37:0] qsum;
	logic signed [31:0] qsat;

	assign lr_s = $signed({1'b0, lr_q});
	assign step = prod2_q[52:16];
	assign qsum = $signed({{6{old_q[31]}}, old_q}) + $signed({step[36], step});

	always_comb begin
		if (qsum[37:31] == 7'b0000000 || qsum[37:31] == 7'b1111111) begin
			qsat = qsum[31:0];
		end else if (qsum[37]) begin
			qsat = 32'sh8000_0000;
		end else begin
			qsat = 32'sh7FFF_FFFF;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			prod1_q <= maxq_q[30:0] * disc_q;
		end
		if (cmd.diff) begin
			diff_q <= $signed({{3{reward_q[31]}}, reward_q}) +
			          $signed({3'b000, prod1_q[47:16]}) -
			          $signed({{3{old_q[31]}}, old_q});
		end
		if (cmd.mul2) begin
			prod2_q <= diff_q * lr_s;
		end
	end

	// pair memory writes: seed on receive, new value on update
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = free_idx_q;
		mem_wdata = '{state: self_q, action: sender_q, q: qlns_pkg::Q_SEED};
		if (cmd.seed) begin
			mem_we = !found_q && free_found_q;
		end else if (cmd.sat) begin
			mem_we    = found_q || free_found_q;
			mem_waddr = found_q ? found_idx_q : free_idx_q;
			mem_wdata = '{state: us_q, action: ua_q, q: qsat};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_valid_q <= '0;
		end else if (mem_we && !found_q) begin
			pair_valid_q[free_idx_q] <= 1'b1;
		end
	end

	// result
	logic [2:0]  verdict_q;
	logic [15:0] hop_q;
	logic [31:0] qres_q;
	logic        full_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			hop_q  <= '0;
			qres_q <= '0;
			full_q <= 1'b0;
		end
		if (cmd.nb_update && !nb_hit && !nb_free_ok) begin
			full_q <= 1'b1;
		end
		if (cmd.seed) begin
			verdict_q <= stat.is_own ? qlns_pkg::VERDICT_OWN : qlns_pkg::VERDICT_DELIVER;
			if (!found_q && !free_found_q) begin
				full_q <= 1'b1;
			end
		end
		if (cmd.sel_finish) begin
			if (best_found_q) begin
				verdict_q <= qlns_pkg::VERDICT_FORWARD;
				hop_q     <= besta_q;
				qres_q    <= best_q;
			end else begin
				verdict_q <= qlns_pkg::VERDICT_DROP;
			end
		end
		if (cmd.sat) begin
			verdict_q <= qlns_pkg::VERDICT_UPDATED;
			qres_q    <= qsat;
			if (!found_q && !free_found_q) begin
				full_q <= 1'b1;
			end
		end
	end

	// output register
	logic                              out_valid_q;
	logic [qlns_pkg::OUT_DATA_W-1:0]   out_data_q;
	logic [qlns_pkg::OUT_USER_W-1:0]   out_user_q;

	assign stat.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= {qres_q, hop_q};
			out_user_q <= {full_q, verdict_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

	a_no_write_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> !rd_issue)
		else $error("pair memory written during sweep");

	a_maxq_floor: assert property (@(posedge clk) disable iff (!arst_n)
		!maxq_q[31])
		else $error("maxQ went negative");

	a_out_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> stat.out_free)
		else $error("output register overwritten");

endmodule

[rtl/qlns_ctrl.sv]
// ----------------------------------------------------------------------------
// qlns_ctrl
// Sequencer: accepts an item, runs the neighbor refresh, the pair sweep,
// the seed, hop selection or the update arithmetic, and hands off the result.
// ----------------------------------------------------------------------------
module qlns_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_op,
	output logic            in_ready,
	input  qlns_pkg::stat_t stat,
	output qlns_pkg::cmd_t  cmd
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_RX_NB  = 10'b00_0000_0010,
		ST_SCAN   = 10'b00_0000_0100,
		ST_SEED   = 10'b00_0000_1000,
		ST_SELECT = 10'b00_0001_0000,
		ST_MUL1   = 10'b00_0010_0000,
		ST_DIFF   = 10'b00_0100_0000,
		ST_MUL2   = 10'b00_1000_0000,
		ST_SAT    = 10'b01_0000_0000,
		ST_DONE   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   op_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in    = 1'b1;
					cmd.scan_start = 1'b1;
					state_d        = in_op ? ST_SCAN : ST_RX_NB;
				end
			end
			ST_RX_NB: begin
				cmd.nb_update = 1'b1;
				state_d       = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan_run = 1'b1;
				if (stat.scan_done) begin
					state_d = op_q ? ST_MUL1 : ST_SEED;
				end
			end
			ST_SEED: begin
				cmd.seed = 1'b1;
				if (stat.is_own || stat.is_deliver) begin
					state_d = ST_DONE;
				end else begin
					cmd.sel_start = 1'b1;
					state_d       = ST_SELECT;
				end
			end
			ST_SELECT: begin
				cmd.sel_run = 1'b1;
				if (stat.sel_done) begin
					cmd.sel_finish = 1'b1;
					state_d        = ST_DONE;
				end
			end
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = ST_DIFF;
			end
			ST_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = ST_SAT;
			end
			ST_SAT: begin
				cmd.sat = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				// hold until the output register can take the result
				if (stat.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_in) begin
				op_q <= in_op;
			end
		end
	end

endmodule

[rtl/qlearning_next_hop_selector.sv]
// One item at a time: a new item is not accepted until the last result is handed off.
// The time per item is set by the sweep of the 64-entry pair memory, one entry per
//   cycle, plus a sweep of the 16-entry neighbor table when hop selection runs.
// Reset: asynchronous, active low; clears all valid bits, config to defaults.
// ----------------------------------------------------------------------------
// qlearning_next_hop_selector
// Q-learning next-hop selection over a neighbor table and a Q-value table.
// ----------------------------------------------------------------------------
module qlearning_next_hop_selector (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// now[31:0] sender[47:32] src_addr[63:48] dst_addr[79:64]
	// upd_state[95:80] upd_action[111:96] reward[143:112]
	input  logic [qlns_pkg::IN_DATA_W-1:0]   s_axis_tdata,
	// op[0]
	input  logic                             s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// next_hop[15:0] q_value[47:16]
	output logic [qlns_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
	// verdict[2:0] table_full[3]
	output logic [qlns_pkg::OUT_USER_W-1:0]  m_axis_tuser,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [31:0]                      cfg_data
);

	qlns_pkg::cmd_t  cmd;
	qlns_pkg::stat_t stat;

	assign cfg_ready = 1'b1;

	qlns_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_op    (s_axis_tuser),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	qlns_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_op     (s_axis_tuser),
		.in_data   (s_axis_tdata),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (m_axis_tdata),
		.out_user  (m_axis_tuser)
	);

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Q-learning next-hop selector. The bench drives
// receive and update transactions, mixed with register writes while the block
// is idle. A predictor keeps its own copy of the neighbor and pair tables and
// works out the verdict, next hop, Q-value and full flag for each transaction.
// ----------------------------------------------------------------------------
class hop_scoreboard;
	bit [15:0] self_a;
	bit [16:0] alpha, gamma;
	bit [31:0] expiry;
	bit nbv[qlns_pkg::NB_SLOTS];
	bit [15:0] nba[qlns_pkg::NB_SLOTS];
	bit [31:0] nbt[qlns_pkg::NB_SLOTS];
	bit pv[qlns_pkg::PAIR_SLOTS];
	bit [15:0] ps[qlns_pkg::PAIR_SLOTS], pa[qlns_pkg::PAIR_SLOTS];
	bit signed [31:0] pq[qlns_pkg::PAIR_SLOTS];
	bit [51:0] pending[$];
	int errors, checked, n_fwd, n_drop, n_full, n_upd;

	function new();
		self_a = 1; alpha = 6554; gamma = 58982; expiry = 30000;
		foreach (nbv[i]) nbv[i] = 0;
		foreach (pv[i]) pv[i] = 0;
	endfunction

	function void write_reg(qlns_pkg::cfg_idx_t idx, bit [31:0] v);
		case (idx)
			qlns_pkg::CFG_SELF_ADDR: self_a = v[15:0];
			qlns_pkg::CFG_LEARN_RATE: alpha = v[16:0];
			qlns_pkg::CFG_DISCOUNT: gamma = v[16:0];
			default: expiry = v;
		endcase
	endfunction

	function int lookup(bit [15:0] s, bit [15:0] a);
		for (int i = 0; i < qlns_pkg::PAIR_SLOTS; i++)
			if (pv[i] && ps[i] == s && pa[i] == a) return i;
		return -1;
	endfunction

	function int free_slot();
		for (int i = 0; i < qlns_pkg::PAIR_SLOTS; i++)
			if (!pv[i]) return i;
		return -1;
	endfunction

	function longint q_of(bit [15:0] s, bit [15:0] a);
		int k;
		k = lookup(s, a);
		return k < 0 ? 0 : longint'(pq[k]);
	endfunction

	// Note an accepted transaction and push its expected result.
	function void note_input(bit op, bit [143:0] d);
		bit [31:0] now;
		bit [15:0] snd, src, dst, us, ua, besta;
		longint rw, maxq, old, diff, qn, prod, q, best;
		int k, slot, fr;
		bit found, full;
		qlns_pkg::verdict_t v;
		now = d[31:0]; snd = d[47:32]; src = d[63:48]; dst = d[79:64];
		us = d[95:80]; ua = d[111:96]; rw = longint'($signed(d[143:112]));
		full = 0; qn = 0; besta = 0;
		if (op) begin
			maxq = 0;
			k = lookup(us, ua);
			old = k < 0 ? 0 : longint'(pq[k]);
			for (int i = 0; i < qlns_pkg::NB_SLOTS; i++)
				if (nbv[i]) begin
					q = q_of(ua, nba[i]);
					if (q > maxq) maxq = q;
				end
			diff = rw + ((maxq * longint'(gamma)) >>> 16) - old;
			prod = diff * longint'(alpha);
			qn = old + (prod >>> 16);
			if (qn > 64'sd2147483647) qn = 64'sd2147483647;
			if (qn < -64'sd2147483648) qn = -64'sd2147483648;
			if (k < 0) begin
				k = free_slot();
				if (k >= 0) begin
					pv[k] = 1; ps[k] = us; pa[k] = ua;
				end else full = 1;
			end
			if (k >= 0) pq[k] = qn[31:0];
			v = qlns_pkg::VERDICT_UPDATED;
			n_upd++;
		end else begin
			slot = -1; fr = -1;
			for (int i = 0; i < qlns_pkg::NB_SLOTS; i++) begin
				if (nbv[i] && nba[i] == snd) slot = i;
				if (!nbv[i] && fr < 0) fr = i;
			end
			if (slot < 0 && fr >= 0) begin
				slot = fr; nbv[slot] = 1; nba[slot] = snd;
			end
			if (slot >= 0) nbt[slot] = now;
			else full = 1;
			if (lookup(self_a, snd) < 0) begin
				k = free_slot();
				if (k >= 0) begin
					pv[k] = 1; ps[k] = self_a; pa[k] = snd; pq[k] = qlns_pkg::Q_SEED;
				end else full = 1;
			end
			if (src == self_a) v = qlns_pkg::VERDICT_OWN;
			else if (dst == self_a) v = qlns_pkg::VERDICT_DELIVER;
			else begin
				found = 0; best = 0;
				for (int i = 0; i < qlns_pkg::NB_SLOTS; i++) begin
					if (!nbv[i]) continue;
					if (now - nbt[i] > expiry) begin
						nbv[i] = 0;
						continue;
					end
					q = q_of(self_a, nba[i]);
					if (!found || q > best || (q == best && nba[i] < besta)) begin
						found = 1; best = q; besta = nba[i];
					end
				end
				if (found) begin
					v = qlns_pkg::VERDICT_FORWARD; qn = best; n_fwd++;
				end else v = qlns_pkg::VERDICT_DROP;
				if (!found) n_drop++;
			end
		end
		if (full) n_full++;
		pending.push_back({full, v, qn[31:0],
			(v == qlns_pkg::VERDICT_FORWARD) ? besta : 16'd0});
	endfunction

	// Compare one accepted result with the oldest expectation.
	function void check_result(bit [47:0] d, bit [3:0] u);
		bit [51:0] e;
		checked++;
		if (pending.size() == 0) begin
			errors++;
			if (errors <= 10) $display("ERROR: unexpected result data=%h user=%h", d, u);
			return;
		end
		e = pending.pop_front();
		if (e[15:0] !== d[15:0] || e[47:16] !== d[47:16] || e[50:48] !== u[2:0]
			|| e[51] !== u[3]) begin
			errors++;
			if (errors <= 10)
				$display("ERROR: result %0d exp verdict=%0d hop=%h q=%h full=%b, got verdict=%0d hop=%h q=%h full=%b",
					checked, e[50:48], e[15:0], e[47:16], e[51], u[2:0], d[15:0], d[47:16], u[3]);
		end
	endfunction
endclass

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	logic clk = 0, arst_n = 0;
	logic s_axis_tvalid = 0, s_axis_tready, s_axis_tuser = 0;
	logic [qlns_pkg::IN_DATA_W-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid, m_axis_tready = 0;
	logic [qlns_pkg::OUT_DATA_W-1:0] m_axis_tdata;
	logic [qlns_pkg::OUT_USER_W-1:0] m_axis_tuser;
	logic cfg_valid = 0, cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	hop_scoreboard sb;
	int send_idle, recv_idle;
	longint cycles;
	bit [15:0] pool[8];
	bit [15:0] my_addr;

	qlearning_next_hop_selector dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 64'd3000000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Receiver side: random stall, check on each accepted transaction.
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata, m_axis_tuser);
			m_axis_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	task automatic send_item(bit op, bit [143:0] d);
		while ($urandom_range(99) < send_idle) @(posedge clk);
		s_axis_tvalid <= 1'b1; s_axis_tuser <= op; s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		sb.note_input(op, d);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(qlns_pkg::cfg_idx_t idx, bit [31:0] v);
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.write_reg(idx, v);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic bit [143:0] pack(bit [31:0] now, bit [15:0] snd, bit [15:0] src,
		bit [15:0] dst, bit [15:0] us, bit [15:0] ua, bit [31:0] rw);
		return {rw, ua, us, dst, src, snd, now};
	endfunction

	function automatic bit [15:0] pick();
		return ($urandom_range(9) == 0) ? 16'($urandom) : pool[$urandom_range(7)];
	endfunction

	// Well-formed traffic over a small address pool, with some wild values.
	task automatic random_items(int n, bit [31:0] step_max);
		bit [31:0] now;
		bit [15:0] s, d;
		now = $urandom;
		for (int i = 0; i < n; i++) begin
			now = now + $urandom_range(step_max);
			if ($urandom_range(3) == 0)
				send_item(1'b1, pack($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
					($urandom_range(3) == 0) ? pick() : my_addr, pick(),
					($urandom_range(4) == 0) ? $urandom : $signed($urandom_range(131072)) - 65536));
			else begin
				s = ($urandom_range(5) == 0) ? my_addr : pick();
				d = ($urandom_range(5) == 0) ? my_addr : pick();
				send_item(1'b0, pack(now, pick(), s, d, 16'($urandom), 16'($urandom), $urandom));
			end
		end
	endtask

	initial begin
		sb = new();
		cycles = 0;
		send_idle = 8; recv_idle = 78;
		foreach (pool[i]) pool[i] = 16'($urandom);
		pool[0] = 16'h0000; pool[1] = 16'hffff;
		my_addr = 16'd1;
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: receive on an empty table, own, deliver, forward, ties, expiry, updates.
		send_item(1'b0, pack(32'd0, 16'h0005, 16'h0009, 16'h0009, 16'd0, 16'd0, 32'd0));
		send_item(1'b0, pack(32'd10, 16'h0003, 16'h0001, 16'h0009, 16'd0, 16'd0, 32'd0));
		send_item(1'b0, pack(32'd20, 16'h0002, 16'h0009, 16'h0001, 16'd0, 16'd0, 32'd0));
		send_item(1'b0, pack(32'd30, 16'h0001, 16'h0008, 16'h0007, 16'd0, 16'd0, 32'd0));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'h0001, 16'h0003, 32'h7fffffff));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'h0001, 16'h0002, 32'h80000000));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'hffff, 32'h00010000));
		send_item(1'b0, pack(32'd40, 16'hffff, 16'hfffe, 16'hfffd, 16'd0, 16'd0, 32'd0));
		send_item(1'b0, pack(32'd30040, 16'h0000, 16'h0004, 16'h0006, 16'd0, 16'd0, 32'd0));
		send_item(1'b0, pack(32'hffffffff, 16'h0003, 16'h0004, 16'h0006, 16'd0, 16'd0, 32'd0));
		send_item(1'b1, pack(32'hffffffff, 16'hffff, 16'hffff, 16'hffff, 16'h0003, 16'h0001,
			32'hffffffff));
		drain();
		write_reg(qlns_pkg::CFG_SELF_ADDR, 32'h0000ffff); my_addr = 16'hffff;
		write_reg(qlns_pkg::CFG_LEARN_RATE, 32'h0001ffff);
		write_reg(qlns_pkg::CFG_DISCOUNT, 32'h0001ffff);
		write_reg(qlns_pkg::CFG_EXPIRY, 32'hffffffff);
		send_item(1'b0, pack(32'd5, 16'h0007, 16'h0009, 16'h0008, 16'd0, 16'd0, 32'd0));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'h0007, 32'h7fffffff));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'hffff, 16'h0007, 32'h7fffffff));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'h0007, 16'h0007, 32'h80000000));
		send_item(1'b0, pack(32'd6, 16'h0008, 16'h0009, 16'h0008, 16'd0, 16'd0, 32'd0));
		drain();
		write_reg(qlns_pkg::CFG_LEARN_RATE, 32'd0);
		write_reg(qlns_pkg::CFG_DISCOUNT, 32'd0);
		write_reg(qlns_pkg::CFG_EXPIRY, 32'd0);
		write_reg(qlns_pkg::CFG_SELF_ADDR, 32'd0); my_addr = 16'h0;
		send_item(1'b0, pack(32'd7, 16'h0008, 16'h0009, 16'h0006, 16'd0, 16'd0, 32'd0));
		send_item(1'b1, pack(32'd0, 16'd0, 16'd0, 16'd0, 16'h0000, 16'h0008, 32'h00020000));
		send_item(1'b0, pack(32'd7, 16'h0009, 16'h0009, 16'h0006, 16'd0, 16'd0, 32'd0));
		drain();

		// Random phases, each under its own settings; the idle mix changes at phases 2 and 4.
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 2) begin send_idle = 78; recv_idle = 8; end
			if (ph == 4) begin send_idle = 0; recv_idle = 0; end
			my_addr = pool[$urandom_range(7)];
			write_reg(qlns_pkg::CFG_SELF_ADDR, {16'd0, my_addr});
			write_reg(qlns_pkg::CFG_LEARN_RATE, (ph == 5) ? 32'd65536 : $urandom_range(70000));
			write_reg(qlns_pkg::CFG_DISCOUNT, (ph == 3) ? 32'd65536 : $urandom_range(70000));
			write_reg(qlns_pkg::CFG_EXPIRY, (ph == 1) ? 32'd0 : $urandom_range(40000));
			random_items(270, (ph == 1) ? 32'd3 : 32'd4000);
			drain();
		end

		$display("Covered %0d results: %0d forwards, %0d drops, %0d updates, %0d table-full.",
			sb.checked, sb.n_fwd, sb.n_drop, sb.n_upd, sb.n_full);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
